/* hdl/lspq_pkg.sv */
// lspq_pkg: shared codes and fixed widths for the linear scan priority queue.
// No dependencies; imported by lspq_ctrl, linear_scan_priority_queue, pq_result_checker and testbench.
`default_nettype none

package lspq_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam int STATUS_BITS     = 2;
	localparam int HELD_COUNT_BITS = 8;

	// Request type code
	localparam logic REQ_INSERT = 1'b0;

endpackage : lspq_pkg

`default_nettype wire

/* hdl/lspq_mem.sv */
// lspq_mem: entry store, one write port and one read port, registered read data.
// No dependencies.
`default_nettype none

module lspq_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 12,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : lspq_mem

`default_nettype wire

/* hdl/lspq_ctrl.sv */
// lspq_ctrl: request sequencer; append on insert, scan/replace on remove.
// Depends on lspq_pkg; drives the ports of lspq_mem.
`default_nettype none

module lspq_ctrl import lspq_pkg::*; #(
	parameter int CAPACITY      = 128,
	parameter int PRIORITY_BITS = 4,
	parameter int TAG_BITS      = 8,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int ENT_W = PRIORITY_BITS + TAG_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request side
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     req_type,
	input  wire logic [PRIORITY_BITS-1:0] entry_priority,
	input  wire logic [TAG_BITS-1:0]      entry_tag,
	// entry store
	output logic                          mem_wr_en,
	output logic      [IDX_W-1:0]         mem_wr_addr,
	output logic      [ENT_W-1:0]         mem_wr_data,
	output logic                          mem_rd_en,
	output logic      [IDX_W-1:0]         mem_rd_addr,
	input  wire logic [ENT_W-1:0]         mem_rd_data,
	// result side
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output status_t                       res_status,
	output logic      [PRIORITY_BITS-1:0] res_priority,
	output logic      [TAG_BITS-1:0]      res_tag,
	output logic      [CNT_W-1:0]         res_count
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		FIX,
		REPORT
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         issue_q;
	logic                     rd_valid_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [TAG_BITS-1:0]      best_tag_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [ENT_W-1:0]         last_q;

	logic                     in_take;
	logic                     is_insert;
	logic                     full;
	logic                     empty;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic [TAG_BITS-1:0]      rd_tag;
	logic [IDX_W-1:0]         last_idx;
	logic                     rd_is_last;
	logic                     take_new;

	assign in_take    = in_valid && (state_q == IDLE);
	assign in_stall   = (state_q != IDLE);
	assign is_insert  = (req_type == REQ_INSERT);
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign empty      = (count_q == '0);
	assign rd_prio    = mem_rd_data[ENT_W-1:TAG_BITS];
	assign rd_tag     = mem_rd_data[TAG_BITS-1:0];
	assign last_idx   = IDX_W'(count_q - CNT_W'(1));
	assign rd_is_last = rd_valid_s1 && (rd_idx_s1 == last_idx);
	// first entry seeds the best; later ones need strictly higher priority
	assign take_new   = (rd_idx_s1 == '0) || (rd_prio > best_prio_q);

	assign res_valid  = (state_q == REPORT);
	assign res_count  = count_q;

	always_comb begin
		mem_rd_en   = (in_take && !is_insert && !empty) ||
		              ((state_q == SCAN) && (issue_q < count_q));
		mem_rd_addr = (state_q == IDLE) ? '0 : issue_q[IDX_W-1:0];
		mem_wr_en   = (in_take && is_insert && !full) || (state_q == FIX);
		if (state_q == FIX) begin
			mem_wr_addr = best_idx_q;
			mem_wr_data = last_q;
		end else begin
			mem_wr_addr = count_q[IDX_W-1:0];
			mem_wr_data = {entry_priority, entry_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			count_q      <= '0;
			issue_q      <= '0;
			rd_valid_s1  <= 1'b0;
			res_status   <= ST_OK;
			res_priority <= '0;
			res_tag      <= '0;
		end else begin
			rd_valid_s1 <= mem_rd_en;
			unique case (state_q)
				IDLE: begin
					if (in_take) begin
						res_priority <= '0;
						res_tag      <= '0;
						if (is_insert) begin
							res_status <= full ? ST_FULL : ST_OK;
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= REPORT;
						end else if (empty) begin
							res_status <= ST_EMPTY;
							state_q    <= REPORT;
						end else begin
							issue_q <= CNT_W'(1);
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					if (mem_rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (rd_is_last) begin
						state_q <= FIX;
					end
				end
				FIX: begin
					count_q      <= count_q - CNT_W'(1);
					res_status   <= ST_OK;
					res_priority <= best_prio_q;
					res_tag      <= best_tag_q;
					state_q      <= REPORT;
				end
				REPORT: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// scan datapath: running best and the last held entry
	always_ff @(posedge clk) begin
		rd_idx_s1 <= mem_rd_addr;
		if ((state_q == SCAN) && rd_valid_s1) begin
			if (take_new) begin
				best_prio_q <= rd_prio;
				best_tag_q  <= rd_tag;
				best_idx_q  <= rd_idx_s1;
			end
			if (rd_is_last) begin
				last_q <= mem_rd_data;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_rd_when_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en |-> ((state_q == SCAN) || ((state_q == IDLE) && in_take)))
		else $error("store read outside a scan");

	a_fix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FIX) |-> (!empty && (best_idx_q <= last_idx)))
		else $error("replacement slot outside held entries");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FIX) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not shrink count");
`endif

endmodule : lspq_ctrl

`default_nettype wire

/* hdl/linear_scan_priority_queue.sv */
// linear_scan_priority_queue: top level; sequencer, entry store and result register.
// Depends on lspq_pkg, lspq_mem and lspq_ctrl.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | in_valid / in_stall  | req_type, entry_priority, entry_tag
//  result   | out_valid / out_stall| status, served_priority, served_tag, held_count
//
// Insert, full insert and empty remove need no scan and go straight to REPORT.
// Remove: the scan reads one held entry per cycle through the single read port
// of the store, then FIX writes the last entry into the freed slot.
// The result register lets a new request in while a result waits at out_stall.
// arst_n clears the count; store contents stay undefined and are never read
// beyond the count.
`default_nettype none

module linear_scan_priority_queue import lspq_pkg::*; #(
	parameter int CAPACITY      = 128,
	parameter int PRIORITY_BITS = 4,
	parameter int TAG_BITS      = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       req_type,
	input  wire logic [PRIORITY_BITS-1:0]   entry_priority,
	input  wire logic [TAG_BITS-1:0]        entry_tag,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [STATUS_BITS-1:0]     status,
	output logic      [PRIORITY_BITS-1:0]   served_priority,
	output logic      [TAG_BITS-1:0]        served_tag,
	output logic      [HELD_COUNT_BITS-1:0] held_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W = PRIORITY_BITS + TAG_BITS;

	// store port wiring
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	logic [ENT_W-1:0] mem_wr_data;
	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	logic [ENT_W-1:0] mem_rd_data;

	// sequencer result
	logic                     res_valid;
	logic                     res_ready;
	status_t                  res_status;
	logic [PRIORITY_BITS-1:0] res_priority;
	logic [TAG_BITS-1:0]      res_tag;
	logic [CNT_W-1:0]         res_count;

	// result register
	logic                       out_valid_q;
	status_t                    status_q;
	logic [PRIORITY_BITS-1:0]   served_priority_q;
	logic [TAG_BITS-1:0]        served_tag_q;
	logic [HELD_COUNT_BITS-1:0] held_count_q;

	lspq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	lspq_ctrl #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS),
		.TAG_BITS      (TAG_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.entry_priority (entry_priority),
		.entry_tag      (entry_tag),
		.mem_wr_en      (mem_wr_en),
		.mem_wr_addr    (mem_wr_addr),
		.mem_wr_data    (mem_wr_data),
		.mem_rd_en      (mem_rd_en),
		.mem_rd_addr    (mem_rd_addr),
		.mem_rd_data    (mem_rd_data),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_status     (res_status),
		.res_priority   (res_priority),
		.res_tag        (res_tag),
		.res_count      (res_count)
	);

	// slot free when empty or being drained this cycle
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			status_q          <= res_status;
			served_priority_q <= res_priority;
			served_tag_q      <= res_tag;
			// held count reports the low bits of the entry count
			held_count_q      <= HELD_COUNT_BITS'(res_count);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign served_priority = served_priority_q;
	assign served_tag      = served_tag_q;
	assign held_count      = held_count_q;

endmodule : linear_scan_priority_queue

`default_nettype wire

/* test/pq_result_checker.sv */
// pq_result_checker: watches the request and result channels of the priority queue,
// keeps a shadow copy of the held entries and compares every result with it.
// Depends on lspq_pkg for the status codes, the request code and the output widths.
module pq_result_checker import lspq_pkg::*; #(
	parameter int CAPACITY      = 128,
	parameter int PRIORITY_BITS = 4,
	parameter int TAG_BITS      = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       req_type,
	input  logic [PRIORITY_BITS-1:0]   entry_priority,
	input  logic [TAG_BITS-1:0]        entry_tag,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [STATUS_BITS-1:0]     status,
	input  logic [PRIORITY_BITS-1:0]   served_priority,
	input  logic [TAG_BITS-1:0]        served_tag,
	input  logic [HELD_COUNT_BITS-1:0] held_count,
	output int                         fail_count,
	output int                         awaiting,
	output int                         served_seen,
	output int                         full_seen,
	output int                         empty_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t                    st;
		logic [PRIORITY_BITS-1:0]   prio;
		logic [TAG_BITS-1:0]        tag;
		logic [HELD_COUNT_BITS-1:0] count;
	} pq_outcome_t;

	// shadow of the queue contents
	logic [PRIORITY_BITS-1:0] held_prio [CAPACITY];
	logic [TAG_BITS-1:0]      held_tag  [CAPACITY];
	int                       held_n;

	pq_outcome_t outcome_q[$];
	pq_outcome_t head;
	pq_outcome_t fresh;

	int n_fail   = 0;
	int n_served = 0;
	int n_full   = 0;
	int n_empty  = 0;

	assign fail_count  = n_fail;
	assign served_seen = n_served;
	assign full_seen   = n_full;
	assign empty_seen  = n_empty;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		n_fail++;
	endtask

	// Applies one request to the shadow queue and returns the result it must produce.
	function automatic pq_outcome_t serve_request(input logic kind,
			input logic [PRIORITY_BITS-1:0] prio, input logic [TAG_BITS-1:0] tag);
		pq_outcome_t r;
		int best;
		r.st   = ST_OK;
		r.prio = '0;
		r.tag  = '0;
		if (kind == REQ_INSERT) begin
			if (held_n >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				held_prio[held_n] = prio;
				held_tag[held_n]  = tag;
				held_n++;
			end
		end else if (held_n == 0) begin
			r.st = ST_EMPTY;
		end else begin
			// strict greater-than keeps the lowest position on a tie
			best = 0;
			for (int i = 1; i < held_n; i++)
				if (held_prio[i] > held_prio[best])
					best = i;
			r.prio          = held_prio[best];
			r.tag           = held_tag[best];
			held_prio[best] = held_prio[held_n-1];
			held_tag[best]  = held_tag[held_n-1];
			held_n--;
		end
		r.count = held_n[HELD_COUNT_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_n = 0;
			outcome_q.delete();
			awaiting <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				fresh = serve_request(req_type, entry_priority, entry_tag);
				case (fresh.st)
					ST_FULL:  n_full++;
					ST_EMPTY: n_empty++;
					default: begin
						if (req_type != REQ_INSERT)
							n_served++;
					end
				endcase
				outcome_q.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result with no request outstanding (status %0d, count %0d)",
						status, held_count));
				end else begin
					head = outcome_q.pop_front();
					if (status !== head.st || served_priority !== head.prio ||
							served_tag !== head.tag || held_count !== head.count)
						report_mismatch($sformatf(
							"got/exp status %0d/%0d prio %0d/%0d tag %0d/%0d count %0d/%0d",
							status, head.st, served_priority, head.prio,
							served_tag, head.tag, held_count, head.count));
				end
			end
			awaiting <= outcome_q.size();
		end
	end

endmodule

/* test/testbench.sv */
// testbench: stimulus, pacing and verdict for linear_scan_priority_queue.
// Depends on lspq_pkg, the queue RTL and pq_result_checker, which checks every result.
module testbench import lspq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   CAPACITY       = 128;
	localparam int   PRIO_W         = 4;
	localparam int   TAG_W          = 8;
	localparam int   CLK_PERIOD     = 10;
	localparam int   RESET_CYCLES   = 6;
	localparam int   HOLD_CYCLES    = 60;    // long result hold-off
	localparam int   WATCHDOG_LIMIT = 1000;  // well above the longest remove plus stalls
	localparam int   TAIL_CYCLES    = 2 * CAPACITY + 10;
	localparam logic REQ_REMOVE     = ~REQ_INSERT;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       req_type;
	logic [PRIO_W-1:0]          entry_priority;
	logic [TAG_W-1:0]           entry_tag;
	logic                       out_valid;
	logic                       out_stall;
	logic [STATUS_BITS-1:0]     status;
	logic [PRIO_W-1:0]          served_priority;
	logic [TAG_W-1:0]           served_tag;
	logic [HELD_COUNT_BITS-1:0] held_count;

	int fail_count;
	int awaiting;
	int served_seen;
	int full_seen;
	int empty_seen;

	// pacing controls for the stimulus and the result sink
	bit src_gaps     = 1'b1;
	bit sink_gaps    = 1'b1;
	bit hold_off_req = 1'b0;
	int sent         = 0;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	linear_scan_priority_queue #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIO_W),
		.TAG_BITS      (TAG_W)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.entry_priority  (entry_priority),
		.entry_tag       (entry_tag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.served_priority (served_priority),
		.served_tag      (served_tag),
		.held_count      (held_count)
	);

	pq_result_checker #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIO_W),
		.TAG_BITS      (TAG_W)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.entry_priority  (entry_priority),
		.entry_tag       (entry_tag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.served_priority (served_priority),
		.served_tag      (served_tag),
		.held_count      (held_count),
		.fail_count      (fail_count),
		.awaiting        (awaiting),
		.served_seen     (served_seen),
		.full_seen       (full_seen),
		.empty_seen      (empty_seen)
	);

	// Offers one request and returns at the edge where it is taken.
	// Entered and left at a rising edge; with src_gaps set, a random gap may first drop valid.
	task automatic send_request(input logic kind, input logic [PRIO_W-1:0] prio,
			input logic [TAG_W-1:0] tag);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= kind;
		entry_priority <= prio;
		entry_tag      <= tag;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// Random requests: insert_pct sets the insert share, prio_max narrows
	// priorities to force ties. Removes carry random junk in the entry fields.
	task automatic run_mix(input int count, input int insert_pct, input int prio_max);
		logic kind;
		repeat (count) begin
			kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
			send_request(kind, PRIO_W'($urandom_range(0, prio_max)),
				TAG_W'($urandom_range(0, (1 << TAG_W) - 1)));
		end
	endtask

	// Sender stays quiet until every predicted result has come back.
	// The first edge lets the checker count the last accepted request.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	// Stimulus and verdict
	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		req_type       <= REQ_INSERT;
		entry_priority <= '0;
		entry_tag      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: remove from empty, field extremes, priority ties decided by
		// position, last entry moved into the freed slot, junk on remove fields.
		send_request(REQ_REMOVE, 4'hF, 8'hFF);
		send_request(REQ_INSERT, 4'h0, 8'h00);
		send_request(REQ_INSERT, 4'hF, 8'hFF);
		send_request(REQ_INSERT, 4'h7, 8'h5A);
		send_request(REQ_INSERT, 4'h7, 8'hA5);
		send_request(REQ_INSERT, 4'hF, 8'h3C);
		send_request(REQ_REMOVE, 4'h0, 8'h00);  // 15/FF, lowest position of the tie
		send_request(REQ_REMOVE, 4'hA, 8'h55);  // 15/3C, moved into slot 1
		send_request(REQ_REMOVE, 4'h5, 8'hAA);  // 7/A5, moved into slot 1 ahead of 7/5A
		send_request(REQ_REMOVE, 4'h0, 8'h00);
		send_request(REQ_REMOVE, 4'h0, 8'h00);  // 0/00, queue now empty
		send_request(REQ_REMOVE, 4'h3, 8'h81);  // empty again
		send_request(REQ_INSERT, 4'hA, 8'h55);
		send_request(REQ_INSERT, 4'h5, 8'hAA);
		send_request(REQ_REMOVE, 4'h0, 8'h00);
		send_request(REQ_REMOVE, 4'h0, 8'h00);
		drain_results();

		// Balanced traffic around a shallow queue
		run_mix(250, 50, 15);

		// Fill past capacity so inserts are refused; the sink holds off at
		// the start so the block backs up and stalls its input.
		hold_off_req = 1'b1;
		run_mix(200, 90, 15);
		drain_results();

		// Drain to empty and keep removing
		run_mix(200, 15, 15);

		// Narrow priorities for many ties, no idling on either side
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		run_mix(150, 55, 2);
		drain_results();

		// Deep queue with idling again
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		run_mix(250, 60, 15);

		// Last stretch runs back to back
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		run_mix(150, 50, 15);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d entries served, %0d inserts refused when full,",
			sent, served_seen, full_seen);
		$display("%0d removes on an empty queue, and a %0d-cycle result hold-off.",
			empty_seen, HOLD_CYCLES);
		if (fail_count == 0 && awaiting == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Result sink: short random stall bursts, plus one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too many cycles with no request or result taken ends the run
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d cycles without progress, %0d results outstanding",
			WATCHDOG_LIMIT, awaiting);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* linear_scan_priority_queue.f */
hdl/lspq_pkg.sv
hdl/lspq_mem.sv
hdl/lspq_ctrl.sv
hdl/linear_scan_priority_queue.sv
test/pq_result_checker.sv
test/testbench.sv
